// ----- hdl/slot_alloc_pkg.sv -----
// Shared types and codes for the block carving slot allocator.
package slot_alloc_pkg;

   // Request action codes
   typedef enum logic [1:0] {
      ACT_ALLOC = 2'd0,
      ACT_FREE  = 2'd1,
      ACT_CLEAR = 2'd2,
      ACT_NOP   = 2'd3
   } action_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EXHAUSTED = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_LEAK      = 2'd3
   } status_type;

   // Controller states, one-hot
   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   // Register indexes (byte address / 4)
   localparam logic REG_SPB = 1'b0;
   localparam logic REG_BPS = 1'b1;

   localparam int unsigned PADDR_W = 3;
   localparam int unsigned SPB_W   = 7;
   localparam int unsigned BPS_W   = 13;

   localparam logic [SPB_W-1:0] SPB_RESET = 7'd8;
   localparam logic [SPB_W-1:0] SPB_MIN   = 7'd1;
   localparam logic [SPB_W-1:0] SPB_MAX   = 7'd64;
   localparam logic [BPS_W-1:0] BPS_RESET = 13'd16;
   localparam logic [BPS_W-1:0] BPS_MIN   = 13'd8;
   localparam logic [BPS_W-1:0] BPS_MAX   = 13'd4096;

   // Output field widths
   localparam int unsigned SLOT_OUT_W = 10;
   localparam int unsigned OFFSET_W   = 22;
   localparam int unsigned USED_W     = 11;

   // Effective (clamped) configuration
   typedef struct packed {
      logic [SPB_W-1:0] spb;
      logic [BPS_W-1:0] bps;
   } cfg_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;
      logic exec;
   } ctrl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

// ----- hdl/slot_alloc_csr.sv -----
// Configuration registers with APB-style access and range clamping.
module slot_alloc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [slot_alloc_pkg::PADDR_W-1:0]  paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready,
   output slot_alloc_pkg::cfg_type             cfg
);

   logic [slot_alloc_pkg::SPB_W-1:0] spb_ff;
   logic [slot_alloc_pkg::BPS_W-1:0] bps_ff;
   logic                             wr_en;
   logic                             reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite & pready;
   assign reg_idx = paddr[2];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         spb_ff <= slot_alloc_pkg::SPB_RESET;
         bps_ff <= slot_alloc_pkg::BPS_RESET;
      end else if (wr_en) begin
         unique case (reg_idx)
            slot_alloc_pkg::REG_SPB: spb_ff <= pwdata[slot_alloc_pkg::SPB_W-1:0];
            slot_alloc_pkg::REG_BPS: bps_ff <= pwdata[slot_alloc_pkg::BPS_W-1:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (reg_idx)
         slot_alloc_pkg::REG_SPB: prdata = 32'(spb_ff);
         slot_alloc_pkg::REG_BPS: prdata = 32'(bps_ff);
         default:                 prdata = '0;
      endcase
   end

   // clamp to the supported ranges
   always_comb begin
      if (spb_ff < slot_alloc_pkg::SPB_MIN)      cfg.spb = slot_alloc_pkg::SPB_MIN;
      else if (spb_ff > slot_alloc_pkg::SPB_MAX) cfg.spb = slot_alloc_pkg::SPB_MAX;
      else                                       cfg.spb = spb_ff;
      if (bps_ff < slot_alloc_pkg::BPS_MIN)      cfg.bps = slot_alloc_pkg::BPS_MIN;
      else if (bps_ff > slot_alloc_pkg::BPS_MAX) cfg.bps = slot_alloc_pkg::BPS_MAX;
      else                                       cfg.bps = bps_ff;
   end

endmodule

// ----- hdl/slot_alloc_ctrl.sv -----
// Controller state machine: accept a request word, then execute it.
module slot_alloc_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  slot_alloc_pkg::dp_status_type dp_status,
   output slot_alloc_pkg::ctrl_cmd_type  cmd
);

   slot_alloc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= slot_alloc_pkg::S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.exec    = 1'b0;
      req_ready   = 1'b0;
      unique case (state_ff)
         slot_alloc_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = slot_alloc_pkg::S_EXEC;
            end
         end
         slot_alloc_pkg::S_EXEC: begin
            // hold until the result register can take the word
            if (dp_status.out_free) begin
               cmd.exec = 1'b1;
               state_in = slot_alloc_pkg::S_IDLE;
            end
         end
         default: state_in = slot_alloc_pkg::S_IDLE;
      endcase
   end

endmodule

// ----- hdl/slot_alloc_dp.sv -----
// Datapath: free list with link memory, block carving, offset multiply, result register.
module slot_alloc_dp #(
   parameter int unsigned POOL_SLOTS = 1024
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  slot_alloc_pkg::ctrl_cmd_type             cmd,
   output slot_alloc_pkg::dp_status_type            dp_status,
   input  slot_alloc_pkg::cfg_type                  cfg,
   input  logic [1:0]                               req_action,
   input  logic [9:0]                               req_slot_in,
   input  logic                                     req_zero_request,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic [1:0]                               rsp_status,
   output logic [slot_alloc_pkg::SLOT_OUT_W-1:0]    rsp_slot_out,
   output logic [slot_alloc_pkg::OFFSET_W-1:0]      rsp_byte_offset,
   output logic                                     rsp_clear_slot,
   output logic [slot_alloc_pkg::USED_W-1:0]        rsp_used_count
);

   localparam int unsigned SLOT_W  = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
   localparam int unsigned CNT_W   = $clog2(POOL_SLOTS + 1);
   localparam int unsigned SPB_W   = slot_alloc_pkg::SPB_W;
   localparam int unsigned SUM_W   = ((CNT_W > SPB_W) ? CNT_W : SPB_W) + 1;
   localparam int unsigned SLOTX_W = (SLOT_W > slot_alloc_pkg::SLOT_OUT_W) ?
                                     SLOT_W : slot_alloc_pkg::SLOT_OUT_W;
   localparam int unsigned USEDX_W = (CNT_W > slot_alloc_pkg::USED_W) ?
                                     CNT_W : slot_alloc_pkg::USED_W;
   localparam int unsigned PROD_W  = slot_alloc_pkg::SLOT_OUT_W + slot_alloc_pkg::BPS_W;

   // captured request word
   slot_alloc_pkg::action_type act_ff;
   logic [9:0]                 slot_in_ff;
   logic                       zero_ff;

   // allocator state
   logic [SLOT_W-1:0] free_head_ff, free_head_in;
   logic [CNT_W-1:0]  free_cnt_ff, free_cnt_in;
   logic [CNT_W-1:0]  carve_ff, carve_in;
   logic [SPB_W-1:0]  remain_ff, remain_in;
   logic [CNT_W-1:0]  in_use_ff, in_use_in;
   logic              pop_pend_ff, pop_pend_in;

   // link memory
   logic [SLOT_W-1:0] link_mem [POOL_SLOTS];
   logic [SLOT_W-1:0] link_rd_ff;
   logic              mem_rd, mem_wr;
   logic [SLOT_W-1:0] wr_addr;

   // result register
   logic                                   rsp_valid_ff;
   logic [1:0]                             status_ff;
   logic [slot_alloc_pkg::SLOT_OUT_W-1:0]  slot_ff;
   logic [slot_alloc_pkg::OFFSET_W-1:0]    offset_ff;
   logic                                   clr_ff;
   logic [slot_alloc_pkg::USED_W-1:0]      used_ff;

   // execute-cycle values
   slot_alloc_pkg::status_type            status_in;
   logic [SLOT_W-1:0]                     slot_sel;
   logic                                  granted;
   logic                                  fits;
   logic [SPB_W-1:0]                      remain_eff;
   logic                                  in_range;
   logic [SLOTX_W-1:0]                    slot_in_x;
   logic [SLOTX_W-1:0]                    slot_x;
   logic [slot_alloc_pkg::SLOT_OUT_W-1:0] slot_out_in;
   logic [PROD_W-1:0]                     prod;
   logic [USEDX_W-1:0]                    used_x;

   assign dp_status.out_free = ~rsp_valid_ff | rsp_ready;

   // capture request word
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff     <= slot_alloc_pkg::action_type'(req_action);
         slot_in_ff <= req_slot_in;
         zero_ff    <= req_zero_request;
      end
   end

   assign slot_in_x = SLOTX_W'(slot_in_ff);
   assign in_range  = (32'(slot_in_ff) < 32'(POOL_SLOTS));
   assign wr_addr   = slot_in_x[SLOT_W-1:0];
   assign fits      = (SUM_W'(carve_ff) + SUM_W'(cfg.spb)) <= SUM_W'(POOL_SLOTS);

   // next state of the allocator for the word in execute
   always_comb begin
      free_head_in = free_head_ff;
      free_cnt_in  = free_cnt_ff;
      carve_in     = carve_ff;
      remain_in    = remain_ff;
      in_use_in    = in_use_ff;
      pop_pend_in  = 1'b0;
      status_in    = slot_alloc_pkg::ST_OK;
      slot_sel     = '0;
      granted      = 1'b0;
      mem_rd       = 1'b0;
      mem_wr       = 1'b0;
      remain_eff   = remain_ff;
      unique case (act_ff)
         slot_alloc_pkg::ACT_ALLOC: begin
            if (free_cnt_ff != '0) begin
               // pop: next head is read from link memory into a register, then loaded as the new head
               slot_sel    = free_head_ff;
               mem_rd      = 1'b1;
               pop_pend_in = 1'b1;
               free_cnt_in = free_cnt_ff - 1'b1;
               granted     = 1'b1;
            end else begin
               // carve a new block when the current one is used up and a new block still fits in the pool
               if (remain_ff == '0 && fits) remain_eff = cfg.spb;
               if (remain_eff != '0) begin
                  slot_sel  = carve_ff[SLOT_W-1:0];
                  carve_in  = carve_ff + 1'b1;
                  remain_in = remain_eff - 1'b1;
                  granted   = 1'b1;
               end
            end
            if (granted) in_use_in = in_use_ff + 1'b1;
            else         status_in = slot_alloc_pkg::ST_EXHAUSTED;
         end
         slot_alloc_pkg::ACT_FREE: begin
            if (in_use_ff == '0) begin
               status_in = slot_alloc_pkg::ST_UNDERFLOW;
            end else if (in_range) begin
               mem_wr       = 1'b1;
               free_head_in = wr_addr;
               free_cnt_in  = free_cnt_ff + 1'b1;
               in_use_in    = in_use_ff - 1'b1;
            end
         end
         slot_alloc_pkg::ACT_CLEAR: begin
            if (in_use_ff != '0) status_in = slot_alloc_pkg::ST_LEAK;
            free_head_in = '0;
            free_cnt_in  = '0;
            carve_in     = '0;
            remain_in    = '0;
            in_use_in    = '0;
         end
         default: ;
      endcase
   end

   // result fields: slot truncated to the port, offset from one multiply
   assign slot_x      = SLOTX_W'(slot_sel);
   assign slot_out_in = slot_x[slot_alloc_pkg::SLOT_OUT_W-1:0];
   assign prod        = PROD_W'(slot_out_in) * PROD_W'(cfg.bps);
   assign used_x      = USEDX_W'(in_use_in);

   // allocator state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff <= '0;
         free_cnt_ff  <= '0;
         carve_ff     <= '0;
         remain_ff    <= '0;
         in_use_ff    <= '0;
         pop_pend_ff  <= 1'b0;
      end else if (cmd.exec) begin
         free_head_ff <= free_head_in;
         free_cnt_ff  <= free_cnt_in;
         carve_ff     <= carve_in;
         remain_ff    <= remain_in;
         in_use_ff    <= in_use_in;
         pop_pend_ff  <= pop_pend_in;
      end else if (pop_pend_ff) begin
         free_head_ff <= link_rd_ff;
         pop_pend_ff  <= 1'b0;
      end
   end

   // link memory: at most one write or one read per executed word
   always_ff @(posedge clock) begin
      if (cmd.exec && mem_wr) link_mem[wr_addr] <= free_head_ff;
      if (cmd.exec && mem_rd) link_rd_ff <= link_mem[free_head_ff];
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset)         rsp_valid_ff <= 1'b0;
      else if (cmd.exec) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff <= status_in;
         slot_ff   <= slot_out_in;
         offset_ff <= prod[slot_alloc_pkg::OFFSET_W-1:0];
         clr_ff    <= granted & zero_ff;
         used_ff   <= used_x[slot_alloc_pkg::USED_W-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_slot_out    = slot_ff;
   assign rsp_byte_offset = offset_ff;
   assign rsp_clear_slot  = clr_ff;
   assign rsp_used_count  = used_ff;

endmodule

// ----- hdl/block_carving_slot_allocator.sv -----
// Top level of the block carving slot allocator.
//
//   channel  direction  handshake          word
//   req      in         req_valid/ready    action, slot_in, zero_request
//   rsp      out        rsp_valid/ready    status, slot_out, byte_offset, clear_slot, used_count
//   csr      in/out     psel/penable       slots_per_block @0x0, bytes_per_slot @0x4
//
// Each word is accepted in S_IDLE, then executed against the free list in S_EXEC.
// A pop reads the link memory into a register; the new head lands in the
//   cycle after execute, which is the accept cycle of the next word.
// A new word is accepted while the previous result still waits; execute holds while
//   the result register is full and not being taken.
// Reset is synchronous; the link memory needs no clearing pass.
module block_carving_slot_allocator #(
   parameter int unsigned POOL_SLOTS = 1024
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [1:0]                              req_action,
   input  logic [9:0]                              req_slot_in,
   input  logic                                    req_zero_request,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [1:0]                              rsp_status,
   output logic [slot_alloc_pkg::SLOT_OUT_W-1:0]   rsp_slot_out,
   output logic [slot_alloc_pkg::OFFSET_W-1:0]     rsp_byte_offset,
   output logic                                    rsp_clear_slot,
   output logic [slot_alloc_pkg::USED_W-1:0]       rsp_used_count,
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [slot_alloc_pkg::PADDR_W-1:0]      paddr,
   input  logic [31:0]                             pwdata,
   output logic [31:0]                             prdata,
   output logic                                    pready
);

   slot_alloc_pkg::cfg_type       cfg;
   slot_alloc_pkg::ctrl_cmd_type  cmd;
   slot_alloc_pkg::dp_status_type dp_status;

   slot_alloc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   slot_alloc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   slot_alloc_dp #(
      .POOL_SLOTS (POOL_SLOTS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .dp_status        (dp_status),
      .cfg              (cfg),
      .req_action       (req_action),
      .req_slot_in      (req_slot_in),
      .req_zero_request (req_zero_request),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_slot_out     (rsp_slot_out),
      .rsp_byte_offset  (rsp_byte_offset),
      .rsp_clear_slot   (rsp_clear_slot),
      .rsp_used_count   (rsp_used_count)
   );

endmodule

// ----- hdl/slot_alloc_chk.sv -----
// Port-level checker for the slot allocator, bound to the top level.
module slot_alloc_chk (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic [1:0]                            rsp_status,
   input logic [slot_alloc_pkg::SLOT_OUT_W-1:0] rsp_slot_out,
   input logic [slot_alloc_pkg::OFFSET_W-1:0]   rsp_byte_offset,
   input logic                                  rsp_clear_slot,
   input logic [slot_alloc_pkg::USED_W-1:0]     rsp_used_count
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slot_out)
         && $stable(rsp_status) && $stable(rsp_used_count))
      else $error("result word changed while stalled");

   // one word in flight: no accept in the cycle after an accept
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous word executes");

   // a refused allocate grants nothing
   a_exhausted_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == slot_alloc_pkg::ST_EXHAUSTED |->
         rsp_slot_out == '0 && rsp_byte_offset == '0 && !rsp_clear_slot)
      else $error("exhausted result carries a slot");

   // underflow and clear both leave nothing in use
   a_empty_after: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == slot_alloc_pkg::ST_UNDERFLOW
         || rsp_status == slot_alloc_pkg::ST_LEAK) |-> rsp_used_count == '0)
      else $error("used count nonzero after underflow or clear");

endmodule

bind block_carving_slot_allocator slot_alloc_chk u_slot_alloc_chk (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_slot_out    (rsp_slot_out),
   .rsp_byte_offset (rsp_byte_offset),
   .rsp_clear_slot  (rsp_clear_slot),
   .rsp_used_count  (rsp_used_count)
);
